// ===== design/supercap_protection_mode_fsm_core_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef SUPERCAP_PROTECTION_MODE_FSM_CORE_MACROS_SVH
`define SUPERCAP_PROTECTION_MODE_FSM_CORE_MACROS_SVH

// Checked on every edge outside reset.
`define SCP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("supercap protection check failed");

// Checked on every edge, reset included.
`define SCP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("supercap protection check failed");

`endif

// ===== design/scp_pkg.sv =====
`default_nettype none
package scp_pkg;

  localparam int ADC_W      = 12;
  localparam int CNT_W      = 16;
  localparam int LED_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_READY   = 3'd1,
    MODE_RUNNING = 3'd2,
    MODE_STOP    = 3'd3,
    MODE_FAULT   = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAP_VOLT_MIN        = 3'd0,
    CFG_SYS_CUR_MAX         = 3'd1,
    CFG_BATTERY_THRESHOLD   = 3'd2,
    CFG_SYS_CURRENT_THRESH  = 3'd3,
    CFG_FAULT_HOLD_TICKS    = 3'd4
  } cfg_reg_t;

  // Converter current windows and other reading thresholds.
  localparam logic [ADC_W-1:0] HARD_HIGH = 12'd4063;
  localparam logic [ADC_W-1:0] HARD_LOW  = 12'd31;
  localparam logic [ADC_W-1:0] SOFT_HIGH = 12'd3443;
  localparam logic [ADC_W-1:0] SOFT_LOW  = 12'd651;
  localparam logic [ADC_W-1:0] INIT_CAP  = 12'd1;
  localparam logic [ADC_W-1:0] READY_CAP = 12'd50;

  // Trip levels of the shared fault counter.
  localparam logic [CNT_W-1:0] TRIP_LOWV = 16'd100;
  localparam logic [CNT_W-1:0] TRIP_HARD = 16'd2;
  localparam logic [CNT_W-1:0] TRIP_SOFT = 16'd30;
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  localparam logic [LED_W-1:0] LED_OFF  = 7'd0;
  localparam logic [LED_W-1:0] LED_MID  = 7'd60;
  localparam logic [LED_W-1:0] LED_HIGH = 7'd80;

  // Register reset values.
  localparam logic [ADC_W-1:0] CAP_VOLT_MIN_RST   = 12'd0;
  localparam logic [ADC_W-1:0] SYS_CUR_MAX_RST    = 12'd4095;
  localparam logic [ADC_W-1:0] BATTERY_THRESH_RST = 12'd2256;
  localparam logic [ADC_W-1:0] SYS_CUR_THRESH_RST = 12'd2047;
  localparam logic [CNT_W-1:0] HOLD_TICKS_RST     = 16'd2000;

  // Everything the mode machine needs to know about one reading set.
  typedef struct packed {
    logic lowv_fault;
    logic hard_out;
    logic soft_out;
    logic cap_above_init;
    logic cap_above_ready;
    logic run_to_stop;
    logic stop_to_ready;
    logic below_cur_max;
  } class_t;

  typedef struct packed {
    mode_t            mode;
    logic             loop_enable;
    logic             converter_enable;
    logic             integrator_clear;
    logic             fault_tripped;
    logic [LED_W-1:0] yellow;
    logic [LED_W-1:0] blue;
    logic [LED_W-1:0] run_light;
  } result_t;

endpackage
`default_nettype wire

// ===== design/supercap_protection_mode_fsm_core.sv =====
// A reading set is written into the queue, then its result is registered onto the outputs.
// Throughput: one reading set per cycle while the output is not stalled.
// in_ready drops only when the two-entry queue fills behind a stalled output.
// Reset (synchronous, rst high): mode INIT, counters, enables and LEDs cleared, queue and
// output emptied, configuration registers back to their default values.
`default_nettype none
module supercap_protection_mode_fsm_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [scp_pkg::ADC_W-1:0]      cap_voltage,
  input  wire logic [scp_pkg::ADC_W-1:0]      system_current,
  input  wire logic [scp_pkg::ADC_W-1:0]      converter_current,
  input  wire logic [scp_pkg::ADC_W-1:0]      battery_voltage,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [scp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scp_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [2:0]                          mode_state,
  output logic                                loop_enable,
  output logic                                converter_enable,
  output logic                                integrator_clear,
  output logic                                fault_tripped,
  output logic [scp_pkg::LED_W-1:0]           yellow_level,
  output logic [scp_pkg::LED_W-1:0]           blue_level,
  output logic [scp_pkg::LED_W-1:0]           run_light_level
);

  scp_pkg::class_t           front_cls;
  scp_pkg::class_t           back_cls;
  logic                      front_valid;
  logic                      front_ready;
  logic                      back_valid;
  logic                      back_ready;
  logic [scp_pkg::CNT_W-1:0] hold_ticks;
  scp_pkg::result_t          res;

  scp_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .cap_voltage       (cap_voltage),
    .system_current    (system_current),
    .converter_current (converter_current),
    .battery_voltage   (battery_voltage),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cls_valid         (front_valid),
    .cls_ready         (front_ready),
    .cls               (front_cls),
    .hold_ticks        (hold_ticks)
  );

  scp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cls),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cls)
  );

  scp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cls_valid  (back_valid),
    .cls_ready  (back_ready),
    .cls        (back_cls),
    .hold_ticks (hold_ticks),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign mode_state       = res.mode;
  assign loop_enable      = res.loop_enable;
  assign converter_enable = res.converter_enable;
  assign integrator_clear = res.integrator_clear;
  assign fault_tripped    = res.fault_tripped;
  assign yellow_level     = res.yellow;
  assign blue_level       = res.blue;
  assign run_light_level  = res.run_light;

endmodule
`default_nettype wire

// ===== design/scp_front.sv =====
`default_nettype none
module scp_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [scp_pkg::ADC_W-1:0]      cap_voltage,
  input  wire logic [scp_pkg::ADC_W-1:0]      system_current,
  input  wire logic [scp_pkg::ADC_W-1:0]      converter_current,
  input  wire logic [scp_pkg::ADC_W-1:0]      battery_voltage,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [scp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scp_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                cls_valid,
  input  wire logic                           cls_ready,
  output scp_pkg::class_t                     cls,
  output logic [scp_pkg::CNT_W-1:0]           hold_ticks
);

  logic [scp_pkg::ADC_W-1:0] cap_volt_min;
  logic [scp_pkg::ADC_W-1:0] sys_cur_max;
  logic [scp_pkg::ADC_W-1:0] battery_threshold;
  logic [scp_pkg::ADC_W-1:0] system_current_threshold;
  logic [scp_pkg::CNT_W-1:0] fault_hold_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_volt_min             <= scp_pkg::CAP_VOLT_MIN_RST;
      sys_cur_max              <= scp_pkg::SYS_CUR_MAX_RST;
      battery_threshold        <= scp_pkg::BATTERY_THRESH_RST;
      system_current_threshold <= scp_pkg::SYS_CUR_THRESH_RST;
      fault_hold_ticks         <= scp_pkg::HOLD_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        scp_pkg::CFG_CAP_VOLT_MIN:       cap_volt_min <= cfg_data[scp_pkg::ADC_W-1:0];
        scp_pkg::CFG_SYS_CUR_MAX:        sys_cur_max <= cfg_data[scp_pkg::ADC_W-1:0];
        scp_pkg::CFG_BATTERY_THRESHOLD:  battery_threshold <= cfg_data[scp_pkg::ADC_W-1:0];
        scp_pkg::CFG_SYS_CURRENT_THRESH: begin
          system_current_threshold <= cfg_data[scp_pkg::ADC_W-1:0];
        end
        scp_pkg::CFG_FAULT_HOLD_TICKS:   fault_hold_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classification is pure comparison against the current register set and the fixed package thresholds.
  always_comb begin
    cls.lowv_fault          = (cap_voltage < cap_volt_min) && (system_current < sys_cur_max);
    cls.hard_out            = (converter_current > scp_pkg::HARD_HIGH) ||
                              (converter_current < scp_pkg::HARD_LOW);
    cls.soft_out            = (converter_current > scp_pkg::SOFT_HIGH) ||
                              (converter_current < scp_pkg::SOFT_LOW);
    cls.cap_above_init      = cap_voltage > scp_pkg::INIT_CAP;
    cls.cap_above_ready     = cap_voltage > scp_pkg::READY_CAP;
    cls.run_to_stop         = (battery_voltage < battery_threshold) &&
                              (system_current < system_current_threshold);
    cls.stop_to_ready       = (battery_voltage > battery_threshold) &&
                              (system_current > system_current_threshold);
    cls.below_cur_max       = system_current < sys_cur_max;
  end

  assign cls_valid  = in_valid;
  assign in_ready   = cls_ready;
  assign hold_ticks = fault_hold_ticks;

endmodule
`default_nettype wire

// ===== design/scp_queue.sv =====
`default_nettype none
module scp_queue (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire scp_pkg::class_t push_data,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output scp_pkg::class_t pop_data
);

  scp_pkg::class_t              entries [scp_pkg::QUEUE_DEPTH];
  logic [scp_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [scp_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [scp_pkg::QUEUE_AW:0]   count;
  logic                         push;
  logic                         pop;

  assign push_ready = count != (scp_pkg::QUEUE_AW+1)'(scp_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/scp_back.sv =====
`default_nettype none
module scp_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cls_valid,
  output logic                      cls_ready,
  input  wire scp_pkg::class_t      cls,
  input  wire logic [scp_pkg::CNT_W-1:0] hold_ticks,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output scp_pkg::result_t          res
);

  scp_pkg::mode_t              mode;
  logic [scp_pkg::CNT_W-1:0]   trip_cnt;
  logic [scp_pkg::CNT_W-1:0]   hold_cnt;
  logic                        loop_en;
  logic                        conv_en;
  logic [scp_pkg::LED_W-1:0]   yellow;
  logic [scp_pkg::LED_W-1:0]   blue;
  logic [scp_pkg::LED_W-1:0]   run_light;

  scp_pkg::mode_t              mode_next;
  logic [scp_pkg::CNT_W-1:0]   trip_cnt_next;
  logic [scp_pkg::CNT_W-1:0]   hold_cnt_next;
  logic                        loop_en_next;
  logic                        conv_en_next;
  logic [scp_pkg::LED_W-1:0]   yellow_next;
  logic [scp_pkg::LED_W-1:0]   blue_next;
  logic [scp_pkg::LED_W-1:0]   run_light_next;
  logic                        tripped;
  logic                        clear;
  logic                        step;

  assign cls_ready = !res_valid || res_ready;
  assign step      = cls_valid && cls_ready;

  always_comb begin
    mode_next      = mode;
    trip_cnt_next  = trip_cnt;
    hold_cnt_next  = hold_cnt;
    loop_en_next   = loop_en;
    conv_en_next   = conv_en;
    yellow_next    = yellow;
    blue_next      = blue;
    run_light_next = run_light;
    tripped        = 1'b0;
    clear          = 1'b0;

    // The three checks run in order on one counter; a trip clears it for the next.
    if (cls.lowv_fault) begin
      if (trip_cnt_next != scp_pkg::CNT_MAX) trip_cnt_next = trip_cnt_next + 1'b1;
      if (trip_cnt_next >= scp_pkg::TRIP_LOWV) begin
        tripped       = 1'b1;
        trip_cnt_next = '0;
      end
    end
    if (cls.hard_out) begin
      if (trip_cnt_next != scp_pkg::CNT_MAX) trip_cnt_next = trip_cnt_next + 1'b1;
      if (trip_cnt_next >= scp_pkg::TRIP_HARD) begin
        tripped       = 1'b1;
        trip_cnt_next = '0;
      end
    end else if (trip_cnt_next != '0) begin
      trip_cnt_next = trip_cnt_next - 1'b1;
    end
    if (cls.soft_out) begin
      if (trip_cnt_next != scp_pkg::CNT_MAX) trip_cnt_next = trip_cnt_next + 1'b1;
      if (trip_cnt_next >= scp_pkg::TRIP_SOFT) begin
        tripped       = 1'b1;
        trip_cnt_next = '0;
      end
    end
    if (tripped) begin
      yellow_next    = scp_pkg::LED_MID;
      blue_next      = scp_pkg::LED_MID;
      run_light_next = scp_pkg::LED_OFF;
      conv_en_next   = 1'b0;
      mode_next      = scp_pkg::MODE_FAULT;
    end

    unique case (mode_next)
      scp_pkg::MODE_INIT: begin
        // Initialisation drops straight into the ready test on the same tick.
        if (cls.cap_above_init) begin
          yellow_next    = scp_pkg::LED_MID;
          blue_next      = scp_pkg::LED_OFF;
          run_light_next = scp_pkg::LED_OFF;
          mode_next      = scp_pkg::MODE_READY;
        end
        if (cls.cap_above_ready) begin
          mode_next      = scp_pkg::MODE_RUNNING;
          yellow_next    = scp_pkg::LED_OFF;
          blue_next      = scp_pkg::LED_OFF;
          run_light_next = scp_pkg::LED_MID;
          conv_en_next   = 1'b1;
        end
      end
      scp_pkg::MODE_READY: begin
        if (cls.cap_above_ready) begin
          mode_next      = scp_pkg::MODE_RUNNING;
          yellow_next    = scp_pkg::LED_OFF;
          blue_next      = scp_pkg::LED_OFF;
          run_light_next = scp_pkg::LED_MID;
          conv_en_next   = 1'b1;
        end
      end
      scp_pkg::MODE_RUNNING: begin
        if (cls.run_to_stop) begin
          mode_next      = scp_pkg::MODE_STOP;
          conv_en_next   = 1'b0;
          yellow_next    = scp_pkg::LED_OFF;
          blue_next      = scp_pkg::LED_OFF;
          run_light_next = scp_pkg::LED_OFF;
        end
      end
      scp_pkg::MODE_STOP: begin
        if (cls.stop_to_ready) begin
          mode_next      = scp_pkg::MODE_READY;
          yellow_next    = scp_pkg::LED_HIGH;
          blue_next      = scp_pkg::LED_OFF;
          run_light_next = scp_pkg::LED_OFF;
        end
      end
      scp_pkg::MODE_FAULT: begin
        if (hold_cnt >= hold_ticks && cls.below_cur_max) begin
          mode_next      = scp_pkg::MODE_READY;
          yellow_next    = scp_pkg::LED_HIGH;
          blue_next      = scp_pkg::LED_OFF;
          run_light_next = scp_pkg::LED_OFF;
        end
      end
      default: ;
    endcase

    unique case (mode_next)
      scp_pkg::MODE_INIT, scp_pkg::MODE_READY: begin
        loop_en_next  = 1'b0;
        hold_cnt_next = '0;
      end
      scp_pkg::MODE_RUNNING: loop_en_next = 1'b1;
      scp_pkg::MODE_STOP:    loop_en_next = 1'b0;
      scp_pkg::MODE_FAULT: begin
        clear = 1'b1;
        if (hold_cnt != scp_pkg::CNT_MAX) hold_cnt_next = hold_cnt + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= scp_pkg::MODE_INIT;
      trip_cnt  <= '0;
      hold_cnt  <= '0;
      loop_en   <= 1'b0;
      conv_en   <= 1'b0;
      yellow    <= scp_pkg::LED_OFF;
      blue      <= scp_pkg::LED_OFF;
      run_light <= scp_pkg::LED_OFF;
      res_valid <= 1'b0;
    end else begin
      if (step) begin
        mode      <= mode_next;
        trip_cnt  <= trip_cnt_next;
        hold_cnt  <= hold_cnt_next;
        loop_en   <= loop_en_next;
        conv_en   <= conv_en_next;
        yellow    <= yellow_next;
        blue      <= blue_next;
        run_light <= run_light_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.mode             <= mode_next;
      res.loop_enable      <= loop_en_next;
      res.converter_enable <= conv_en_next;
      res.integrator_clear <= clear;
      res.fault_tripped    <= tripped;
      res.yellow           <= yellow_next;
      res.blue             <= blue_next;
      res.run_light        <= run_light_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/scp_checker.sv =====
`default_nettype none
`include "supercap_protection_mode_fsm_core_macros.svh"
module scp_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [2:0]                     mode_state,
  input wire logic                           loop_enable,
  input wire logic                           converter_enable,
  input wire logic                           integrator_clear,
  input wire logic                           fault_tripped,
  input wire logic [scp_pkg::LED_W-1:0]      yellow_level,
  input wire logic [scp_pkg::LED_W-1:0]      blue_level,
  input wire logic [scp_pkg::LED_W-1:0]      run_light_level
);

  logic                           in_fault;
  logic                           in_run;
  logic [3*scp_pkg::LED_W+2:0]    shown;

  assign in_fault = mode_state == scp_pkg::MODE_FAULT;
  assign in_run   = mode_state == scp_pkg::MODE_RUNNING;
  assign shown    = {mode_state, yellow_level, blue_level, run_light_level};

  // A stalled result keeps its mode and indicator levels.
  `SCP_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(shown))

  // Integrators are only cleared while the block sits in FAULT.
  `SCP_ASSERT(a_clear_in_fault, out_valid && integrator_clear |-> in_fault)

  // A trip always leaves the converter stopped.
  `SCP_ASSERT(a_trip_stops_conv, out_valid && fault_tripped |-> !converter_enable)

  // Loops run only in RUNNING, or stay as they were while in FAULT.
  `SCP_ASSERT(a_loop_mode, out_valid && loop_enable |-> in_run || in_fault)

  // Reset empties the output register.
  `SCP_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid)

endmodule

bind supercap_protection_mode_fsm_core scp_checker u_scp_checker (.*);
`default_nettype wire
